/* rtl/fgp_pkg.sv */
// Shared types, constants and the 5x7 font table of the glyph pixel generator.
package fgp_pkg;

  localparam int unsigned CELL_COLS  = 6;
  localparam int unsigned CELL_ROWS  = 8;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] FIRST_CODE = 8'h20;  // space
  localparam logic [7:0] LAST_CODE  = 8'h5F;  // underscore
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam logic [2:0] LAST_ROW = 3'(CELL_ROWS - 1);
  localparam logic [2:0] LAST_COL = 3'(CELL_COLS - 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_COLUMN_OFFSET = 2'd0,
    REG_ROW_OFFSET    = 2'd1
  } cfg_reg_t;

  // One classified character waiting for pixel generation
  typedef struct packed {
    logic [39:0] glyph;     // column c in bits [8c+7:8c], bit r is row r
    logic [15:0] win_x;
    logic [15:0] win_y;
    logic [15:0] ink;
    logic [15:0] paper;
  } job_t;

  // Fold lower case, map out of range codes to space, index from space
  function automatic logic [5:0] rom_index(input logic [7:0] code);
    logic [7:0] folded;
    folded = code;
    if (code >= LOWER_A && code <= LOWER_Z) begin
      folded = code - CASE_DIFF;
    end
    if (folded < FIRST_CODE || folded > LAST_CODE) begin
      folded = FIRST_CODE;
    end
    return 6'(folded - FIRST_CODE);
  endfunction

  // Font table: five column bytes, column 0 in the low byte
  function automatic logic [39:0] glyph_bits(input logic [5:0] idx);
    logic [39:0] g;
    unique case (idx)
      6'd13:   g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      6'd15:   g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
      6'd16:   g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      6'd17:   g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      6'd18:   g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      6'd19:   g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      6'd20:   g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      6'd21:   g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      6'd22:   g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      6'd23:   g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      6'd24:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd25:   g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      6'd26:   g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
      6'd33:   g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      6'd34:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
      6'd35:   g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd36:   g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
      6'd37:   g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      6'd38:   g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
      6'd39:   g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
      6'd40:   g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      6'd41:   g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      6'd42:   g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
      6'd43:   g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
      6'd44:   g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
      6'd45:   g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      6'd46:   g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
      6'd47:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd48:   g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
      6'd49:   g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
      6'd50:   g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      6'd51:   g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
      6'd52:   g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      6'd53:   g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      6'd54:   g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      6'd55:   g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      6'd56:   g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      6'd57:   g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      6'd58:   g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
      6'd63:   g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

/* rtl/fgp_front.sv */
// Front end: offset registers, request accept, glyph lookup and window start.
module fgp_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  input  logic         in_valid,
  input  logic         queue_full,
  input  logic [7:0]   in_char_code,
  input  logic [15:0]  in_origin_x,
  input  logic [15:0]  in_origin_y,
  input  logic [15:0]  in_ink_color,
  input  logic [15:0]  in_paper_color,
  output logic         in_stall,
  output logic         push,
  output fgp_pkg::job_t push_job
);
  import fgp_pkg::*;

  logic [7:0] col_off_r, col_off_nxt;
  logic [7:0] row_off_r, row_off_nxt;

  // Decode configuration writes; unknown indexes are dropped
  always_comb begin
    col_off_nxt = col_off_r;
    row_off_nxt = row_off_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMN_OFFSET: col_off_nxt = cfg_data;
        REG_ROW_OFFSET:    row_off_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_off_r <= '0;
      row_off_r <= '0;
    end else begin
      col_off_r <= col_off_nxt;
      row_off_r <= row_off_nxt;
    end
  end

  // Hold requests while the queue is full
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Classify the character and build the job
  always_comb begin
    push_job.glyph = glyph_bits(rom_index(in_char_code));
    push_job.win_x = in_origin_x + {8'h00, col_off_r};
    push_job.win_y = in_origin_y + {8'h00, row_off_r};
    push_job.ink   = in_ink_color;
    push_job.paper = in_paper_color;
  end

endmodule

/* rtl/fgp_queue.sv */
// Two-entry job queue between front and back end.
module fgp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fgp_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output fgp_pkg::job_t head_job
);
  import fgp_pkg::*;

  job_t       entry_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'(QUEUE_DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign head_job  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/fgp_back.sv */
// Back end: walks each job's 8x6 cell, registering one pixel a cycle unless stalled.
module fgp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_avail,
  input  fgp_pkg::job_t head_job,
  output logic          pop,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [15:0]   out_pixel_value,
  output logic [2:0]    out_cell_row,
  output logic [2:0]    out_cell_column,
  output logic [15:0]   out_window_x_start,
  output logic [15:0]   out_window_y_start,
  output logic          out_last_pixel
);
  import fgp_pkg::*;

  job_t        job_r, job_nxt;
  logic        busy_r, busy_nxt;
  logic [2:0]  row_r, row_nxt;
  logic [2:0]  col_r, col_nxt;
  logic        ov_r, ov_nxt;
  logic [15:0] pix_r, pix_nxt;
  logic [2:0]  orow_r, orow_nxt;
  logic [2:0]  ocol_r, ocol_nxt;
  logic [15:0] owx_r, owx_nxt;
  logic [15:0] owy_r, owy_nxt;
  logic        olast_r, olast_nxt;

  logic        advance;
  logic        at_last;
  logic [47:0] cell_bits;
  logic        ink_bit;

  // Spacing column reads as zero bits
  assign cell_bits = {8'h00, job_r.glyph};
  assign ink_bit   = cell_bits[{col_r, row_r}];
  assign at_last   = (row_r == LAST_ROW) && (col_r == LAST_COL);
  assign advance   = busy_r && (!ov_r || !out_stall);
  assign pop       = job_avail && (!busy_r || (advance && at_last));

  // Step through the cell and load the output register
  always_comb begin
    job_nxt   = job_r;
    busy_nxt  = busy_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    ov_nxt    = (ov_r && out_stall) || advance;
    pix_nxt   = pix_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    owx_nxt   = owx_r;
    owy_nxt   = owy_r;
    olast_nxt = olast_r;
    if (advance) begin
      pix_nxt   = ink_bit ? job_r.ink : job_r.paper;
      orow_nxt  = row_r;
      ocol_nxt  = col_r;
      owx_nxt   = job_r.win_x;
      owy_nxt   = job_r.win_y;
      olast_nxt = at_last;
      if (col_r == LAST_COL) begin
        col_nxt = '0;
        row_nxt = row_r + 3'd1;
      end else begin
        col_nxt = col_r + 3'd1;
      end
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
    // Take the next job when idle or as the current one finishes
    if (pop) begin
      job_nxt  = head_job;
      busy_nxt = 1'b1;
      row_nxt  = '0;
      col_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    pix_r   <= pix_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    owx_r   <= owx_nxt;
    owy_r   <= owy_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid          = ov_r;
  assign out_pixel_value    = pix_r;
  assign out_cell_row       = orow_r;
  assign out_cell_column    = ocol_r;
  assign out_window_x_start = owx_r;
  assign out_window_y_start = owy_r;
  assign out_last_pixel     = olast_r;

endmodule

/* rtl/font_glyph_pixel_generator_top.sv */
// Top level of the 5x7 character generator with RGB565 pixel output.
//
//  channel | direction | handshake           | payload
//  in_     | request   | in_valid / in_stall | char_code, origin_x/y, ink/paper color
//  out_    | request   | out_valid/out_stall | pixel, cell row/column, window x/y, last
//  cfg_    | write     | cfg_we              | cfg_index, cfg_data
//
// Each character request yields 48 pixel requests, row by row, one per cycle
// while the output is not stalled; the pixel walk of the back end sets the rate.
// A two-entry queue lets the next characters be taken while one is drawn,
// so consecutive cells stream with no gap. Reset is synchronous, active low,
// and clears both offsets. A stall on the output holds the pixel register
// and the walk; the input stalls only while the queue is full.
module font_glyph_pixel_generator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic [15:0] in_origin_x,
  input  logic [15:0] in_origin_y,
  input  logic [15:0] in_ink_color,
  input  logic [15:0] in_paper_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel_value,
  output logic [2:0]  out_cell_row,
  output logic [2:0]  out_cell_column,
  output logic [15:0] out_window_x_start,
  output logic [15:0] out_window_y_start,
  output logic        out_last_pixel
);
  import fgp_pkg::*;

  logic queue_full;
  logic queue_avail;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  fgp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .queue_full     (queue_full),
    .in_char_code   (in_char_code),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_ink_color   (in_ink_color),
    .in_paper_color (in_paper_color),
    .in_stall       (in_stall),
    .push           (push),
    .push_job       (push_job)
  );

  fgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_avail),
    .head_job  (head_job)
  );

  fgp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_avail          (queue_avail),
    .head_job           (head_job),
    .pop                (pop),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_pixel_value    (out_pixel_value),
    .out_cell_row       (out_cell_row),
    .out_cell_column    (out_cell_column),
    .out_window_x_start (out_window_x_start),
    .out_window_y_start (out_window_y_start),
    .out_last_pixel     (out_last_pixel)
  );

  // Last flag marks exactly the bottom right pixel
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_pixel == ((out_cell_row == LAST_ROW) &&
                                      (out_cell_column == LAST_COL))))
    else $error("last_pixel does not match cell position");

  // Within a cell the next pixel follows without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_pixel |=> out_valid)
    else $error("gap inside a character cell");

  // Column steps by one and wraps after the spacing column
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_pixel |=>
      ((($past(out_cell_column) == LAST_COL) && (out_cell_column == 3'd0)) ||
       (($past(out_cell_column) != LAST_COL) &&
        (out_cell_column == $past(out_cell_column) + 3'd1))))
    else $error("cell column out of sequence");

  // Window start holds for the whole cell
  a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_pixel |=>
      $stable(out_window_x_start) && $stable(out_window_y_start))
    else $error("window start changed inside a cell");

endmodule
